// ===== hdl/block_average_downscaler_core_assert.svh =====
// Assertion macros for the block average downscaler.
// Used by the top level only; expands to nothing when SYNTHESIS is defined.
`ifndef BLOCK_AVERAGE_DOWNSCALER_CORE_ASSERT_SVH
`define BLOCK_AVERAGE_DOWNSCALER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BAVG_ASSERT(label, clk_sig, rst_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error("block_average_downscaler_core: assertion failed");
`define BAVG_NEVER(label, clk_sig, rst_sig, expr) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(expr)) \
        else $error("block_average_downscaler_core: forbidden condition");
`else
`define BAVG_ASSERT(label, clk_sig, rst_sig, prop)
`define BAVG_NEVER(label, clk_sig, rst_sig, expr)
`endif
`endif

// ===== hdl/bavg_pkg.sv =====
// Shared types and constants for the block average downscaler.
// No dependencies; imported by the controller, the datapath and the top level.
package bavg_pkg;

    localparam int PIX_PORT_W = 16;
    localparam int FACTOR_W   = 5;
    localparam int COLS_W     = 11;
    localparam int ROWS_W     = 16;
    localparam int ROW_W      = 16;
    localparam int SUM_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd2;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET  = 5'd2;
    localparam logic [COLS_W-1:0]   COLUMNS_RESET = 11'd1024;
    localparam logic [ROWS_W-1:0]   ROWS_RESET    = 16'd1024;

    // divider job select
    typedef logic [2:0] div_sel_t;
    localparam div_sel_t DSEL_COL   = 3'd0;  // column_index / f
    localparam div_sel_t DSEL_ROW   = 3'd1;  // row_index / f
    localparam div_sel_t DSEL_OCOLS = 3'd2;  // columns / f
    localparam div_sel_t DSEL_OROWS = 3'd3;  // rows / f
    localparam div_sel_t DSEL_AVG   = 3'd4;  // block sum / f^2

    typedef struct packed {
        logic     clear;
        logic     accept;
        logic     sum_write;
        logic     div_start;
        div_sel_t div_sel;
        logic     out_load;
    } bavg_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic emit;
        logic div_done;
    } bavg_status_t;

endpackage

// ===== hdl/bavg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bavg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/bavg_div.sv =====
// Restoring divider, one quotient bit per cycle.
// No dependencies; used by the datapath for all divides.
module bavg_div #(
    parameter int N = 32,
    parameter int D = 14
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         done,
    output logic [N-1:0] quotient,
    output logic [D-1:0] remainder
);

    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  q_reg;
    logic [D-1:0]  r_reg;
    logic [D-1:0]  d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [D:0]    r_shift;
    logic [D:0]    r_diff;
    logic          ge;

    assign r_shift = {r_reg, q_reg[N-1]};
    assign r_diff  = r_shift - {1'b0, d_reg};
    assign ge      = r_shift >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(N);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[N-2:0], ge};
            r_reg <= ge ? r_diff[D-1:0] : r_shift[D-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

// ===== hdl/bavg_datapath.sv =====
// Datapath: config registers, raster position counters, column sum RAM,
// shared divider and output word registers. Depends on bavg_pkg, bavg_ram, bavg_div.
module bavg_datapath import bavg_pkg::*; #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_FACTOR  = 16,
    parameter int PIXEL_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bavg_cmd_t             cmd,
    output bavg_status_t          status,
    input  logic [PIX_PORT_W-1:0] pixel,
    input  logic                  frame_start,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [PIX_PORT_W-1:0] average,
    output logic                  last_in_row,
    output logic                  last_in_frame
);

    localparam int CI_W = $clog2(MAX_COLUMNS + 1);
    localparam int AW   = $clog2(MAX_COLUMNS);
    localparam int FW   = $clog2(MAX_FACTOR + 1);
    localparam int DV_W = 2 * FW;
    localparam logic [SUM_W-1:0] PIX_MAX = SUM_W'((64'd1 << PIXEL_BITS) - 64'd1);

    // configuration
    logic [FACTOR_W-1:0] factor_reg;
    logic [COLS_W-1:0]   columns_reg;
    logic [ROWS_W-1:0]   rows_reg;
    logic [FW-1:0]       f_eff;
    logic [FW-1:0]       f_m1;
    logic [DV_W-1:0]     f_sq;
    logic [CI_W-1:0]     cols_eff;
    logic [ROW_W-1:0]    rows_eff;

    // position state; cm/rm and b/rb track index % f and index / f
    logic [CI_W-1:0]  ci_reg, b_reg, out_cols_reg;
    logic [ROW_W-1:0] ri_reg, rb_reg, out_rows_reg;
    logic [FW-1:0]    cib_reg, rib_reg, cm_reg, rm_reg;
    logic [AW-1:0]    clr_addr_reg;

    logic [CI_W-1:0]  ci, b, ci_inc, ci_next, b_next;
    logic [ROW_W-1:0] ri, rb, ri_inc, ri_next, rb_next;
    logic [FW-1:0]    cib, rib, cm, rm, cib_next, rib_next, cm_next, rm_next;
    logic [FW:0]      cib_inc, rib_inc, cm_inc, rm_inc;
    logic             cib_wrap, rib_wrap, cm_wrap, rm_wrap, col_end, row_end;
    logic             hit, first, emit_now, lr, lf;

    // per-word registers
    logic [PIXEL_BITS-1:0] pix_reg;
    logic [AW-1:0]         addr_reg;
    logic                  hit_reg, first_reg, emit_reg, lr_reg, lf_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      sum;
    logic [SUM_W-1:0]      rd_data;
    logic [PIX_PORT_W-1:0] average_reg;
    logic                  lr_out_reg, lf_out_reg;

    // divider
    logic [SUM_W-1:0] div_dividend, quotient, avg_sat;
    logic [DV_W-1:0]  div_divisor, remainder;
    logic             div_done;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [SUM_W-1:0] ram_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg  <= FACTOR_RESET;
            columns_reg <= COLUMNS_RESET;
            rows_reg    <= ROWS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FACTOR:  factor_reg  <= cfg_data[FACTOR_W-1:0];
                CFG_COLUMNS: columns_reg <= cfg_data[COLS_W-1:0];
                CFG_ROWS:    rows_reg    <= cfg_data[ROWS_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        if (factor_reg == '0)
            f_eff = FW'(1);
        else if (32'(factor_reg) > 32'(MAX_FACTOR))
            f_eff = FW'(MAX_FACTOR);
        else
            f_eff = FW'(factor_reg);

        if (columns_reg == '0)
            cols_eff = CI_W'(1);
        else if (32'(columns_reg) > 32'(MAX_COLUMNS))
            cols_eff = CI_W'(MAX_COLUMNS);
        else
            cols_eff = CI_W'(columns_reg);

        rows_eff = (rows_reg == '0) ? ROW_W'(1) : rows_reg;
    end

    assign f_m1 = f_eff - FW'(1);
    assign f_sq = {{FW{1'b0}}, f_eff} * {{FW{1'b0}}, f_eff};

    // frame start zeroes every position before the pixel is placed
    assign ci  = frame_start ? '0 : ci_reg;
    assign ri  = frame_start ? '0 : ri_reg;
    assign cib = frame_start ? '0 : cib_reg;
    assign rib = frame_start ? '0 : rib_reg;
    assign cm  = frame_start ? '0 : cm_reg;
    assign rm  = frame_start ? '0 : rm_reg;
    assign b   = frame_start ? '0 : b_reg;
    assign rb  = frame_start ? '0 : rb_reg;

    assign hit      = (b < out_cols_reg) && (rb < out_rows_reg);
    assign first    = (rib == '0) && (cib == '0);
    assign emit_now = (rib == f_m1) && (cib == f_m1);
    assign lr       = (b == out_cols_reg - CI_W'(1));
    assign lf       = lr && (rb == out_rows_reg - ROW_W'(1));

    assign ci_inc   = ci + CI_W'(1);
    assign ri_inc   = ri + ROW_W'(1);
    assign cib_inc  = {1'b0, cib} + (FW+1)'(1);
    assign rib_inc  = {1'b0, rib} + (FW+1)'(1);
    assign cm_inc   = {1'b0, cm} + (FW+1)'(1);
    assign rm_inc   = {1'b0, rm} + (FW+1)'(1);
    assign cib_wrap = cib_inc >= {1'b0, f_eff};
    assign rib_wrap = rib_inc >= {1'b0, f_eff};
    assign cm_wrap  = cm_inc >= {1'b0, f_eff};
    assign rm_wrap  = rm_inc >= {1'b0, f_eff};
    assign col_end  = ci_inc >= cols_eff;
    assign row_end  = ri_inc >= rows_eff;

    always_comb
    begin
        ci_next  = ci_inc;
        cib_next = cib_wrap ? '0 : cib_inc[FW-1:0];
        cm_next  = cm_wrap ? '0 : cm_inc[FW-1:0];
        b_next   = cm_wrap ? b + CI_W'(1) : b;
        ri_next  = ri;
        rib_next = rib;
        rm_next  = rm;
        rb_next  = rb;
        if (col_end)
        begin
            ci_next  = '0;
            cib_next = '0;
            cm_next  = '0;
            b_next   = '0;
            ri_next  = ri_inc;
            rib_next = rib_wrap ? '0 : rib_inc[FW-1:0];
            rm_next  = rm_wrap ? '0 : rm_inc[FW-1:0];
            rb_next  = rm_wrap ? rb + ROW_W'(1) : rb;
            if (row_end)
            begin
                ri_next  = '0;
                rib_next = '0;
                rm_next  = '0;
                rb_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ci_reg       <= '0;
            ri_reg       <= '0;
            cib_reg      <= '0;
            rib_reg      <= '0;
            cm_reg       <= '0;
            rm_reg       <= '0;
            b_reg        <= '0;
            rb_reg       <= '0;
            out_cols_reg <= '0;
            out_rows_reg <= '0;
        end
        else if (cmd.accept)
        begin
            ci_reg  <= ci_next;
            ri_reg  <= ri_next;
            cib_reg <= cib_next;
            rib_reg <= rib_next;
            cm_reg  <= cm_next;
            rm_reg  <= rm_next;
            b_reg   <= b_next;
            rb_reg  <= rb_next;
        end
        else if (div_done)
        begin
            // refresh quotient/remainder trackers after a config write or the reset sweep
            case (cmd.div_sel)
                DSEL_COL:
                begin
                    b_reg  <= CI_W'(quotient);
                    cm_reg <= FW'(remainder);
                end
                DSEL_ROW:
                begin
                    rb_reg <= ROW_W'(quotient);
                    rm_reg <= FW'(remainder);
                end
                DSEL_OCOLS: out_cols_reg <= CI_W'(quotient);
                DSEL_OROWS: out_rows_reg <= ROW_W'(quotient);
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            hit_reg      <= 1'b0;
            first_reg    <= 1'b0;
            emit_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.accept)
            begin
                hit_reg   <= hit;
                first_reg <= first;
                emit_reg  <= hit && emit_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg  <= pixel[PIXEL_BITS-1:0];
            addr_reg <= b[AW-1:0];
            lr_reg   <= lr;
            lf_reg   <= lf;
        end
        if (cmd.sum_write)
        begin
            sum_reg <= sum;
        end
        if (cmd.out_load)
        begin
            average_reg <= PIX_PORT_W'(avg_sat);
            lr_out_reg  <= lr_reg;
            lf_out_reg  <= lf_reg;
        end
    end

    // first pixel of a block reloads the column sum
    assign sum = first_reg ? SUM_W'(pix_reg) : rd_data + SUM_W'(pix_reg);

    assign ram_we    = cmd.clear || (cmd.sum_write && hit_reg);
    assign ram_waddr = cmd.clear ? clr_addr_reg : addr_reg;
    assign ram_wdata = cmd.clear ? '0 : sum;

    bavg_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_COLUMNS)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.accept),
        .raddr (b[AW-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        div_divisor = {{FW{1'b0}}, f_eff};
        case (cmd.div_sel)
            DSEL_COL:   div_dividend = SUM_W'(ci_reg);
            DSEL_ROW:   div_dividend = SUM_W'(ri_reg);
            DSEL_OCOLS: div_dividend = SUM_W'(cols_eff);
            DSEL_OROWS: div_dividend = SUM_W'(rows_eff);
            DSEL_AVG:
            begin
                div_dividend = sum_reg;
                div_divisor  = f_sq;
            end
            default:    div_dividend = sum_reg;
        endcase
    end

    bavg_div #(
        .N (SUM_W),
        .D (DV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    assign avg_sat = (quotient > PIX_MAX) ? PIX_MAX : quotient;

    assign status.clr_done = (clr_addr_reg == AW'(MAX_COLUMNS - 1));
    assign status.emit     = emit_reg;
    assign status.div_done = div_done;

    assign average       = average_reg;
    assign last_in_row   = lr_out_reg;
    assign last_in_frame = lf_out_reg;

endmodule

// ===== hdl/bavg_ctrl.sv =====
// Controller FSM: handshakes, RAM clear sweep, divider job sequencing.
// Depends on bavg_pkg; drives the datapath through bavg_cmd_t.
module bavg_ctrl import bavg_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  bavg_status_t status,
    output bavg_cmd_t    cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DWAIT  = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0] state_reg, state_next;
    div_sel_t   sel_reg, sel_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        cmd         = '0;
        cmd.div_sel = sel_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clr_done)
                begin
                    sel_next   = DSEL_COL;
                    state_next = S_DSTART;
                end
            end
            S_IDLE:
            begin
                // a config write wins over a pixel in the same cycle
                if (cfg_valid)
                begin
                    sel_next   = DSEL_COL;
                    state_next = S_DSTART;
                end
                else if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.sum_write = 1'b1;
                if (status.emit)
                begin
                    sel_next   = DSEL_AVG;
                    state_next = S_DSTART;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (status.div_done)
                begin
                    case (sel_reg)
                        DSEL_COL:
                        begin
                            sel_next   = DSEL_ROW;
                            state_next = S_DSTART;
                        end
                        DSEL_ROW:
                        begin
                            sel_next   = DSEL_OCOLS;
                            state_next = S_DSTART;
                        end
                        DSEL_OCOLS:
                        begin
                            sel_next   = DSEL_OROWS;
                            state_next = S_DSTART;
                        end
                        DSEL_AVG:   state_next = S_OUT;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sel_reg       <= DSEL_COL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready = state_reg inside {S_IDLE, S_CLEAR};
    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/block_average_downscaler_core.sv =====
// Top level of the block average downscaler; depends on bavg_pkg, bavg_ctrl,
// bavg_datapath and the assertion macros in block_average_downscaler_core_assert.svh.
// Grayscale pixels enter in raster order and each output word is the truncated mean
// of one F by F block, sent when the block's last pixel arrives, with row and frame
// end flags; partial blocks at the right and bottom edges are dropped. A pixel that
// does not finish a block takes one read-modify-write of the column sum RAM; a pixel
// that finishes a block also runs the 32-step shared divider that forms sum / (F*F),
// and input stalls until its word is loaded for output. After reset the column sum
// RAM is swept to zero, followed by a refresh of the divide-derived counters; every
// configuration write triggers that same refresh, during which in_stall is high and
// cfg_ready low. Write configuration only while the block is idle.
`include "block_average_downscaler_core_assert.svh"

module block_average_downscaler_core import bavg_pkg::*; #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_FACTOR  = 16,
    parameter int PIXEL_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_PORT_W-1:0] pixel,
    input  logic                  frame_start,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIX_PORT_W-1:0] average,
    output logic                  last_in_row,
    output logic                  last_in_frame,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    bavg_cmd_t    cmd;
    bavg_status_t status;
    logic         cfg_we;

    assign cfg_we = cfg_valid && cfg_ready;

    bavg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bavg_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_FACTOR  (MAX_FACTOR),
        .PIXEL_BITS  (PIXEL_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .pixel         (pixel),
        .frame_start   (frame_start),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .average       (average),
        .last_in_row   (last_in_row),
        .last_in_frame (last_in_frame)
    );

    // a pixel word and a config write never land on the same edge
    `BAVG_NEVER(a_no_cfg_with_pixel, clk, rst_n, (in_valid && !in_stall) && cfg_we)
    // the read-modify-write cycle always follows an accepted word
    `BAVG_ASSERT(a_stall_after_accept, clk, rst_n, (in_valid && !in_stall) |=> in_stall)
    `BAVG_ASSERT(a_write_after_accept, clk, rst_n, cmd.sum_write |-> $past(cmd.accept))
    // never overwrite a result word that is still waiting
    `BAVG_ASSERT(a_out_load_free, clk, rst_n, cmd.out_load |-> (!out_valid || !out_stall))

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for block_average_downscaler_core: a directed table, then random frames under
// random register settings, each word checked against the table or an in-bench scaler model.
// Depends on bavg_pkg and the RTL of block_average_downscaler_core.
module testbench;
    import bavg_pkg::*;

    localparam int MAX_COLUMNS    = 1024;
    localparam int MAX_FACTOR     = 16;
    localparam int PIXEL_MAX      = 65535;
    localparam int RANDOM_PIXELS  = 800;
    localparam int PHASE_CAP      = 300;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PLAN_LEN       = 33;

    // index 3 is decoded by nobody
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [PIX_PORT_W-1:0] average;
        logic                  last_in_row;
        logic                  last_in_frame;
    } block_result_t;

    typedef enum logic [1:0] {STEP_FACTOR, STEP_COLUMNS, STEP_ROWS, STEP_PIXEL} step_kind_t;
    typedef enum logic [1:0] {WANT_MODEL, WANT_NOTHING, WANT_WORD} want_t;

    typedef struct {
        step_kind_t            kind;
        logic [15:0]           value;
        logic                  fs;
        want_t                 want;
        logic [PIX_PORT_W-1:0] average;
        logic                  lr;
        logic                  lf;
    } directed_step_t;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic [PIX_PORT_W-1:0] pixel         = '0;
    logic                  frame_start   = 1'b0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic [PIX_PORT_W-1:0] average;
    logic                  last_in_row;
    logic                  last_in_frame;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_FACTOR;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // scaler model state
    logic [FACTOR_W-1:0] factor_reg  = FACTOR_RESET;
    logic [COLS_W-1:0]   columns_reg = COLUMNS_RESET;
    logic [ROWS_W-1:0]   rows_reg    = ROWS_RESET;
    logic [31:0]         block_sums [MAX_COLUMNS];
    int unsigned         scan_column     = 0;
    int unsigned         scan_row        = 0;
    int unsigned         block_row_phase = 0;
    int unsigned         block_col_phase = 0;

    block_result_t pending_blocks [$];
    block_result_t oldest_block;
    int unsigned   errors_seen  = 0;
    int unsigned   stuck_cycles = 0;
    int unsigned   hold_cycles  = 0;
    bit            burst_mode   = 1'b0;

    directed_step_t directed_plan [PLAN_LEN] = '{
        '{STEP_FACTOR,  16'd2,     1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_COLUMNS, 16'd4,     1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_ROWS,    16'd2,     1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        // 4x2 frame, two blocks
        '{STEP_PIXEL,   16'd0,     1'b1, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd65535, 1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd100,   1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd200,   1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd0,     1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd65535, 1'b0, WANT_WORD,    16'd32767, 1'b0, 1'b0},
        '{STEP_PIXEL,   16'd300,   1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd401,   1'b0, WANT_WORD,    16'd250,   1'b1, 1'b1},
        // counters wrap on their own, then a frame start cuts the frame short
        '{STEP_PIXEL,   16'd65535, 1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd65535, 1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd1,     1'b0, WANT_MODEL,   16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd2,     1'b0, WANT_MODEL,   16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd65535, 1'b1, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd65535, 1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd0,     1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd0,     1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd65535, 1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd65535, 1'b0, WANT_WORD,    16'd65535, 1'b0, 1'b0},
        '{STEP_PIXEL,   16'd3,     1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd5,     1'b0, WANT_WORD,    16'd2,     1'b1, 1'b1},
        // zero in every register: a 1x1 image, factor 1
        '{STEP_FACTOR,  16'd0,     1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_COLUMNS, 16'd0,     1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_ROWS,    16'd0,     1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd12345, 1'b0, WANT_WORD,    16'd12345, 1'b1, 1'b1},
        '{STEP_PIXEL,   16'd0,     1'b0, WANT_WORD,    16'd0,     1'b1, 1'b1},
        // clamped factor and width, image shorter than one block
        '{STEP_FACTOR,  16'd31,    1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_COLUMNS, 16'd2047,  1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_ROWS,    16'd3,     1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd77,    1'b1, WANT_NOTHING, 16'd0,     1'b0, 1'b0},
        '{STEP_PIXEL,   16'd65535, 1'b0, WANT_NOTHING, 16'd0,     1'b0, 1'b0}
    };

    block_average_downscaler_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel         (pixel),
        .frame_start   (frame_start),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .average       (average),
        .last_in_row   (last_in_row),
        .last_in_frame (last_in_frame),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Advances the scaler model by one pixel; returns 1 when the pixel closes a block.
    function automatic bit downscale_pixel(input logic [15:0] pix, input logic fs,
                                           output block_result_t res);
        int unsigned f, cols, rows, out_cols, out_rows, blk, mean;
        bit          hit;
        f    = (factor_reg == '0) ? 1 :
               ((32'(factor_reg) > MAX_FACTOR) ? MAX_FACTOR : 32'(factor_reg));
        cols = (columns_reg == '0) ? 1 :
               ((32'(columns_reg) > MAX_COLUMNS) ? MAX_COLUMNS : 32'(columns_reg));
        rows = (rows_reg == '0) ? 1 : 32'(rows_reg);
        out_cols = cols / f;
        out_rows = rows / f;
        hit = 1'b0;
        res = '0;
        if (fs)
        begin
            scan_column     = 0;
            scan_row        = 0;
            block_row_phase = 0;
            block_col_phase = 0;
        end
        if (scan_column < out_cols * f && scan_row < out_rows * f)
        begin
            blk = scan_column / f;
            if (block_row_phase == 0 && block_col_phase == 0)
                block_sums[blk] = 32'(pix);
            else
                block_sums[blk] = block_sums[blk] + 32'(pix);
            if (block_row_phase == f - 1 && block_col_phase == f - 1)
            begin
                mean = block_sums[blk] / (f * f);
                if (mean > PIXEL_MAX)
                    mean = PIXEL_MAX;
                res.average       = 16'(mean);
                res.last_in_row   = (blk == out_cols - 1);
                res.last_in_frame = res.last_in_row && (scan_row / f == out_rows - 1);
                hit = 1'b1;
            end
        end
        block_col_phase = (block_col_phase + 1 >= f) ? 0 : block_col_phase + 1;
        scan_column = scan_column + 1;
        if (scan_column >= cols)
        begin
            scan_column     = 0;
            block_col_phase = 0;
            block_row_phase = (block_row_phase + 1 >= f) ? 0 : block_row_phase + 1;
            scan_row = scan_row + 1;
            if (scan_row >= rows)
            begin
                scan_row        = 0;
                block_row_phase = 0;
            end
        end
        return hit;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_pixel(input logic [15:0] pix, input logic fs);
        int unsigned gap;
        gap = burst_mode ? 0 : idle_length();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        pixel       <= pix;
        frame_start <= fs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Register write; bits above the register width sometimes carry junk.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        logic [15:0] keep;
        logic [15:0] data;
        case (idx)
            CFG_FACTOR:  keep = 16'h001F;
            CFG_COLUMNS: keep = 16'h07FF;
            default:     keep = 16'hFFFF;
        endcase
        data = value;
        if ($urandom_range(0, 2) == 0)
            data = (value & keep) | (16'($urandom) & ~keep);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_FACTOR:  factor_reg  = data[FACTOR_W-1:0];
            CFG_COLUMNS: columns_reg = data[COLS_W-1:0];
            CFG_ROWS:    rows_reg    = data[ROWS_W-1:0];
            default:     ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, drain every expected word, then give a pixel still in flight time to retire.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // output stall pattern
    always @(negedge clk)
    begin
        if (hold_cycles != 0)
            hold_cycles = hold_cycles - 1;
        else if (out_stall)
        begin
            out_stall <= 1'b0;
            hold_cycles = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 30);
        end
        else
        begin
            hold_cycles = idle_length();
            if (hold_cycles != 0)
            begin
                out_stall <= 1'b1;
                hold_cycles = hold_cycles - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_blocks.size() == 0)
            begin
                $error("unexpected word: average %0d, last_in_row %0b, last_in_frame %0b",
                       average, last_in_row, last_in_frame);
                errors_seen = errors_seen + 1;
            end
            else
            begin
                oldest_block = pending_blocks.pop_front();
                if (average !== oldest_block.average)
                begin
                    $error("average: expected %0d, actual %0d", oldest_block.average, average);
                    errors_seen = errors_seen + 1;
                end
                if (last_in_row !== oldest_block.last_in_row)
                begin
                    $error("last_in_row: expected %0b, actual %0b",
                           oldest_block.last_in_row, last_in_row);
                    errors_seen = errors_seen + 1;
                end
                if (last_in_frame !== oldest_block.last_in_frame)
                begin
                    $error("last_in_frame: expected %0b, actual %0b",
                           oldest_block.last_in_frame, last_in_frame);
                    errors_seen = errors_seen + 1;
                end
            end
        end
    end

    // watchdog: no word moved on any channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall) ||
            (cfg_valid && cfg_ready))
            stuck_cycles = 0;
        else
        begin
            stuck_cycles = stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        block_result_t word;
        bit            hit;
        int unsigned   random_pixels;
        int unsigned   phase;
        int unsigned   count;
        int unsigned   cols_eff;
        int unsigned   rows_eff;
        logic [15:0]   new_factor;
        logic [15:0]   new_columns;
        logic [15:0]   new_rows;
        logic [15:0]   pix;
        logic          fs;
        logic          opens_frame;

        foreach (block_sums[i])
            block_sums[i] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
        begin
            case (directed_plan[i].kind)
                STEP_FACTOR:
                begin
                    settle();
                    write_register(CFG_FACTOR, directed_plan[i].value);
                end
                STEP_COLUMNS:
                begin
                    settle();
                    write_register(CFG_COLUMNS, directed_plan[i].value);
                end
                STEP_ROWS:
                begin
                    settle();
                    write_register(CFG_ROWS, directed_plan[i].value);
                end
                default:
                begin
                    hit = downscale_pixel(directed_plan[i].value, directed_plan[i].fs, word);
                    case (directed_plan[i].want)
                        WANT_WORD:
                            pending_blocks.push_back('{directed_plan[i].average,
                                                       directed_plan[i].lr,
                                                       directed_plan[i].lf});
                        WANT_MODEL:
                            if (hit)
                                pending_blocks.push_back(word);
                        default: ;
                    endcase
                    send_pixel(directed_plan[i].value, directed_plan[i].fs);
                end
            endcase
        end

        random_pixels = 0;
        phase = 0;
        while (random_pixels < RANDOM_PIXELS)
        begin
            settle();
            case (phase)
                0:
                begin
                    new_factor = 16'd16; new_columns = 16'd16; new_rows = 16'd16;
                end
                1:
                begin
                    new_factor = 16'd1; new_columns = 16'd1024; new_rows = 16'd65535;
                end
                default:
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: new_factor = 16'($urandom_range(1, 4));
                        6, 7:             new_factor = 16'($urandom_range(5, 16));
                        default:          new_factor = 16'($urandom_range(0, 31));
                    endcase
                    case ($urandom_range(0, 9))
                        8:       new_columns = 16'($urandom_range(0, 2047));
                        9:       new_columns = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'd1024;
                        default: new_columns = 16'($urandom_range(1, 24));
                    endcase
                    case ($urandom_range(0, 9))
                        8:       new_rows = 16'($urandom_range(0, 65535));
                        9:       new_rows = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'd65535;
                        default: new_rows = 16'($urandom_range(1, 12));
                    endcase
                end
            endcase
            if (phase < 2 || $urandom_range(0, 2) != 0)
                write_register(CFG_FACTOR, new_factor);
            if (phase < 2 || $urandom_range(0, 2) != 0)
                write_register(CFG_COLUMNS, new_columns);
            if (phase < 2 || $urandom_range(0, 2) != 0)
                write_register(CFG_ROWS, new_rows);
            if ($urandom_range(0, 7) == 0)
                write_register(CFG_UNUSED, 16'($urandom));

            burst_mode = ($urandom_range(0, 3) == 0);
            cols_eff = (columns_reg == '0) ? 1 :
                       ((32'(columns_reg) > MAX_COLUMNS) ? MAX_COLUMNS : 32'(columns_reg));
            rows_eff = (rows_reg == '0) ? 1 : 32'(rows_reg);
            count = cols_eff * rows_eff * $urandom_range(1, 3);
            if (count > PHASE_CAP)
                count = PHASE_CAP;
            if (count > RANDOM_PIXELS - random_pixels)
                count = RANDOM_PIXELS - random_pixels;
            // most phases open a clean frame; the rest carry on from where the counters stand
            opens_frame = (phase < 2) || ($urandom_range(0, 4) != 0);
            for (int k = 0; k < count; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       pix = '0;
                    1:       pix = 16'(PIXEL_MAX);
                    default: pix = 16'($urandom);
                endcase
                fs = (k == 0) ? opens_frame : ($urandom_range(0, 49) == 0);
                hit = downscale_pixel(pix, fs, word);
                if (hit)
                    pending_blocks.push_back(word);
                send_pixel(pix, fs);
            end
            random_pixels = random_pixels + count;
            phase = phase + 1;
        end

        burst_mode = 1'b0;
        settle();
        if (errors_seen == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bavg_pkg.sv
hdl/bavg_ram.sv
hdl/bavg_div.sv
hdl/bavg_datapath.sv
hdl/bavg_ctrl.sv
hdl/block_average_downscaler_core.sv
tb/sv/testbench.sv
